// ----- hdl/lru_key_value_cache_defines.svh -----
// Assertion macros for the key/value cache. The enclosing module must provide
// clk and arst_n.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef ASSERT_OFF
`define LKV_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("lkv: assertion failed");
`define LKV_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("lkv: assertion failed");
`else
`define LKV_ASSERT(label, prop)
`define LKV_ASSERT_NEXT(label, pre, post)
`endif

`endif

// ----- hdl/lkv_pkg.sv -----
`default_nettype none
package lkv_pkg;
	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 5;
	localparam int DATA_W   = 32;

	localparam logic [OCC_W-1:0]  OCC_MAX   = '1;
	localparam logic [DATA_W-1:0] ALL_ONES  = '1;
	localparam logic [DATA_W-1:0] STAMP_MAX = '1;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_GET    = 2'd0;
	localparam cmd_t CMD_INSERT = 2'd1;
	localparam cmd_t CMD_REMOVE = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Result of one scan over the entry memory.
	typedef struct packed {
		logic              match_found;
		idx_t              match_idx;
		logic [DATA_W-1:0] match_value;
		logic              free_found;
		idx_t              free_idx;
		logic              old_found;
		idx_t              old_idx;
	} scan_res_t;
endpackage
`default_nettype wire

// ----- hdl/lkv_if.sv -----
`default_nettype none
interface lkv_req_if;
	import lkv_pkg::*;
	logic               valid;
	logic               ready;
	cmd_t               command;
	logic signed [31:0] key;
	logic signed [31:0] value;
	modport source(output valid, command, key, value, input ready);
	modport sink(input valid, command, key, value, output ready);
endinterface

interface lkv_rsp_if;
	import lkv_pkg::*;
	logic               valid;
	logic               ready;
	logic               found;
	logic signed [31:0] read_value;
	logic [OCC_W-1:0]   occupancy;
	modport source(output valid, found, read_value, occupancy, input ready);
	modport sink(input valid, found, read_value, occupancy, output ready);
endinterface
`default_nettype wire

// ----- hdl/lkv_ram.sv -----
`default_nettype none
module lkv_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 96,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hdl/lkv_scan.sv -----
`default_nettype none
module lkv_scan (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      cmp_vld,
	input  wire lkv_pkg::idx_t             cmp_idx,
	input  wire logic                      cmp_valid_bit,
	input  wire lkv_pkg::entry_t           entry,
	input  wire logic [lkv_pkg::DATA_W-1:0] key,
	output lkv_pkg::scan_res_t             res
);
	import lkv_pkg::*;

	logic              match_found_q;
	idx_t              match_idx_q;
	logic [DATA_W-1:0] match_value_q;
	logic              free_found_q;
	idx_t              free_idx_q;
	logic              old_found_q;
	idx_t              old_idx_q;
	logic [DATA_W-1:0] old_stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			old_found_q   <= 1'b0;
		end else if (start) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			old_found_q   <= 1'b0;
		end else if (cmp_vld) begin
			if (cmp_valid_bit && entry.key == key && !match_found_q) begin
				match_found_q <= 1'b1;
			end
			if (!cmp_valid_bit) begin
				free_found_q <= 1'b1;
			end
			if (cmp_valid_bit) begin
				old_found_q <= 1'b1;
			end
		end
	end

	// Entries are visited in ascending order, so the first hit is the lowest index
	// and a strict compare keeps the lowest index among equal stamps.
	always_ff @(posedge clk) begin
		if (cmp_vld && !start) begin
			if (cmp_valid_bit && entry.key == key && !match_found_q) begin
				match_idx_q   <= cmp_idx;
				match_value_q <= entry.value;
			end
			if (!cmp_valid_bit && !free_found_q) begin
				free_idx_q <= cmp_idx;
			end
			if (cmp_valid_bit && (!old_found_q || entry.stamp < old_stamp_q)) begin
				old_idx_q   <= cmp_idx;
				old_stamp_q <= entry.stamp;
			end
		end
	end

	assign res.match_found = match_found_q;
	assign res.match_idx   = match_idx_q;
	assign res.match_value = match_value_q;
	assign res.free_found  = free_found_q;
	assign res.free_idx    = free_idx_q;
	assign res.old_found   = old_found_q;
	assign res.old_idx     = old_idx_q;
endmodule
`default_nettype wire

// ----- hdl/lru_key_value_cache.sv -----
// Fully associative key/value cache with least-recently-used replacement.
// Each request transaction carries a get, insert or remove; each produces
// exactly one response transaction with found, read_value and occupancy.
// Each response is registered; the entry memory has a single read port,
// so the key match, the first free slot and the oldest stamp are found by
// one pass reading one entry per cycle, followed by a single write-back.
// One request is in flight at a time; the next is accepted in the cycle
// after the response is registered, even if it has not been taken yet, so
// a request is not taken until the last one is written back. A response
// that is still waiting holds the following request in its write-back cycle.
// No clearing pass follows reset, since entry validity is held in flip-flops.
`default_nettype none
`include "lru_key_value_cache_defines.svh"
module lru_key_value_cache (
	input  wire logic clk,
	input  wire logic arst_n,
	lkv_req_if.sink   req,
	lkv_rsp_if.source rsp
);
	import lkv_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_LAST  = 4'b0100,
		S_WRITE = 4'b1000
	} state_t;

	localparam idx_t LAST_IDX = IDX_W'(CAPACITY - 1);

	state_t              state_q;
	idx_t                rd_idx_q;
	logic                cmp_vld_s1;
	idx_t                cmp_idx_s1;
	cmd_t                cmd_q;
	logic [DATA_W-1:0]   key_q;
	logic [DATA_W-1:0]   value_q;
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DATA_W-1:0]   use_cnt_q;

	logic                rsp_valid_q;
	logic                found_q;
	logic [DATA_W-1:0]   read_value_q;
	logic [OCC_W-1:0]    occupancy_q;

	logic                accept;
	logic                do_write;
	logic                ram_re;
	entry_t              ram_rdata;
	logic                we;
	idx_t                waddr;
	entry_t              wdata;
	scan_res_t           res;

	logic [DATA_W-1:0]   stamp_next;
	logic                bump;
	logic                set_valid;
	logic                clr_valid;
	idx_t                valid_idx;
	logic [CNT_W-1:0]    cnt_next;
	logic                found_next;
	logic [DATA_W-1:0]   read_value_next;
	logic [31:0]         cnt_wide;
	logic [OCC_W-1:0]    occ_next;

	assign accept   = req.valid && req.ready;
	assign do_write = (state_q == S_WRITE) && (!rsp_valid_q || rsp.ready);
	assign ram_re   = (state_q == S_SCAN);

	assign req.ready = (state_q == S_IDLE);

	lkv_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(ENTRY_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ram_re),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	lkv_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (accept),
		.cmp_vld      (cmp_vld_s1),
		.cmp_idx      (cmp_idx_s1),
		.cmp_valid_bit(valid_q[cmp_idx_s1]),
		.entry        (ram_rdata),
		.key          (key_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= ram_re;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_idx_q == LAST_IDX) begin
						state_q <= S_LAST;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				S_LAST: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (do_write) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_idx_q;
		if (accept) begin
			cmd_q   <= req.command;
			key_q   <= req.key;
			value_q <= req.value;
		end
	end

	assign stamp_next = (use_cnt_q == STAMP_MAX) ? use_cnt_q : use_cnt_q + DATA_W'(1);

	always_comb begin
		we              = 1'b0;
		waddr           = res.match_idx;
		wdata.key       = key_q;
		wdata.value     = value_q;
		wdata.stamp     = stamp_next;
		bump            = 1'b0;
		set_valid       = 1'b0;
		clr_valid       = 1'b0;
		valid_idx       = res.match_idx;
		cnt_next        = cnt_q;
		found_next      = 1'b0;
		read_value_next = ALL_ONES;
		case (cmd_q)
			CMD_GET: begin
				if (res.match_found) begin
					we              = 1'b1;
					wdata.value     = res.match_value;
					bump            = 1'b1;
					found_next      = 1'b1;
					read_value_next = res.match_value;
				end
			end
			CMD_INSERT: begin
				bump = 1'b1;
				if (res.match_found) begin
					we         = 1'b1;
					found_next = 1'b1;
				end else if (res.free_found) begin
					we        = 1'b1;
					waddr     = res.free_idx;
					set_valid = 1'b1;
					valid_idx = res.free_idx;
					cnt_next  = cnt_q + CNT_W'(1);
				end else if (res.old_found) begin
					we        = 1'b1;
					waddr     = res.old_idx;
				end else begin
					bump = 1'b0;
				end
			end
			CMD_REMOVE: begin
				if (res.match_found) begin
					clr_valid  = 1'b1;
					cnt_next   = cnt_q - CNT_W'(1);
					found_next = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (!do_write) begin
			we        = 1'b0;
			bump      = 1'b0;
			set_valid = 1'b0;
			clr_valid = 1'b0;
		end
	end

	// Occupancy saturates at the field maximum for large capacities.
	assign cnt_wide = 32'(cnt_next);
	assign occ_next = (cnt_wide > 32'(OCC_MAX)) ? OCC_MAX : cnt_wide[OCC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			cnt_q       <= '0;
			use_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (set_valid) begin
				valid_q[valid_idx] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[valid_idx] <= 1'b0;
			end
			if (do_write) begin
				cnt_q       <= cnt_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (bump) begin
				use_cnt_q <= stamp_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			found_q      <= found_next;
			read_value_q <= read_value_next;
			occupancy_q  <= occ_next;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.found      = found_q;
	assign rsp.read_value = read_value_q;
	assign rsp.occupancy  = occupancy_q;

	`LKV_ASSERT(a_cnt_matches_valid, cnt_q == CNT_W'($countones(valid_q)))
	`LKV_ASSERT(a_use_cnt_monotonic, use_cnt_q >= $past(use_cnt_q))
	`LKV_ASSERT_NEXT(a_write_returns, do_write, state_q == S_IDLE && rsp_valid_q)
endmodule
`default_nettype wire

// ----- tb/lru_key_value_cache_checker.sv -----
module lru_key_value_cache_checker
	import lkv_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	lkv_req_if          req,
	lkv_rsp_if          rsp,
	output int unsigned errors,
	output int unsigned pending,
	output int unsigned answered,
	output int unsigned get_hits,
	output int unsigned evictions
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] read_value;
		logic [OCC_W-1:0]  occupancy;
	} answer_t;

	logic [DATA_W-1:0] slot_key   [CAPACITY];
	logic [DATA_W-1:0] slot_value [CAPACITY];
	logic [DATA_W-1:0] slot_stamp [CAPACITY];
	bit                slot_live  [CAPACITY];
	logic [DATA_W-1:0] use_count;
	answer_t           answers_due[$];

	function automatic logic [DATA_W-1:0] bump_stamp();
		if (use_count != STAMP_MAX)
			use_count++;
		return use_count;
	endfunction

	// Applies one transaction to the mirrored store and returns the answer it earns.
	function automatic answer_t lookup_and_update(cmd_t cmd, logic [DATA_W-1:0] k,
		logic [DATA_W-1:0] v);
		answer_t a;
		int hit;
		int spot;
		int live;
		a.found = 1'b0;
		a.read_value = ALL_ONES;
		hit = -1;
		for (int i = 0; i < CAPACITY; i++)
			if (hit < 0 && slot_live[i] && slot_key[i] == k)
				hit = i;
		case (cmd)
			CMD_GET: begin
				if (hit >= 0) begin
					slot_stamp[hit] = bump_stamp();
					a.read_value = slot_value[hit];
					a.found = 1'b1;
					get_hits++;
				end
			end
			CMD_INSERT: begin
				if (hit >= 0) begin
					slot_value[hit] = v;
					slot_stamp[hit] = bump_stamp();
					a.found = 1'b1;
				end else begin
					spot = -1;
					for (int i = 0; i < CAPACITY; i++)
						if (spot < 0 && !slot_live[i])
							spot = i;
					if (spot < 0) begin
						// Store is full: the smallest stamp goes, lowest index on a tie.
						spot = 0;
						for (int i = 1; i < CAPACITY; i++)
							if (slot_stamp[i] < slot_stamp[spot])
								spot = i;
						evictions++;
					end
					slot_key[spot] = k;
					slot_value[spot] = v;
					slot_stamp[spot] = bump_stamp();
					slot_live[spot] = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (hit >= 0) begin
					slot_live[hit] = 1'b0;
					a.found = 1'b1;
				end
			end
			default: ;
		endcase
		live = 0;
		for (int i = 0; i < CAPACITY; i++)
			live += slot_live[i];
		a.occupancy = (live > OCC_MAX) ? OCC_MAX : OCC_W'(live);
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				slot_key[i] = '0;
				slot_value[i] = '0;
				slot_stamp[i] = '0;
				slot_live[i] = 1'b0;
			end
			use_count = '0;
			answers_due.delete();
			errors = 0;
			answered = 0;
			get_hits = 0;
			evictions = 0;
			pending <= 0;
		end else begin
			if (req.valid === 1'b1 && req.ready === 1'b1)
				answers_due.insert(answers_due.size(),
					lookup_and_update(req.command, req.key, req.value));
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				answered++;
				if (answers_due.size() == 0) begin
					errors++;
					$display("%0t: response with no request waiting: expected none, got %b %h %0d",
						$time, rsp.found, rsp.read_value, rsp.occupancy);
				end else begin
					want = answers_due.pop_front();
					if (rsp.found !== want.found) begin
						errors++;
						$display("%0t: found expected %b, got %b", $time, want.found, rsp.found);
					end
					if (rsp.read_value !== want.read_value) begin
						errors++;
						$display("%0t: read_value expected %h, got %h",
							$time, want.read_value, rsp.read_value);
					end
					if (rsp.occupancy !== want.occupancy) begin
						errors++;
						$display("%0t: occupancy expected %0d, got %0d",
							$time, want.occupancy, rsp.occupancy);
					end
				end
			end
			pending <= answers_due.size();
		end
	end
endmodule

// ----- tb/lru_key_value_cache_test.sv -----
module lru_key_value_cache_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lkv_pkg::*;

	localparam cmd_t        CMD_UNUSED  = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          PHASES      = 6;
	localparam int          PHASE_ITEMS = 175;
	localparam int          POOL_SIZE   = 32;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned src_gap_pct;
	int unsigned snk_gap_pct;
	int unsigned cycle_count;
	int unsigned errors;
	int unsigned pending;
	int unsigned answered;
	int unsigned get_hits;
	int unsigned evictions;

	lkv_req_if req_ch();
	lkv_rsp_if rsp_ch();

	lru_key_value_cache dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	lru_key_value_cache_checker mirror (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.errors    (errors),
		.pending   (pending),
		.answered  (answered),
		.get_hits  (get_hits),
		.evictions (evictions)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("lru_key_value_cache: mismatch");
			$finish;
		end
	end

	// The valid line stays high from one transaction into the next unless a gap is taken.
	task automatic issue(input cmd_t cmd, input logic [DATA_W-1:0] k,
		input logic [DATA_W-1:0] v);
		if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.key <= k;
		req_ch.value <= v;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
	endtask

	initial begin
		int unsigned hold;
		hold = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold == 0 && snk_gap_pct != 0 && $urandom_range(0, 99) < snk_gap_pct)
				hold = $urandom_range(1, 5);
			if (hold != 0) begin
				rsp_ch.ready <= 1'b0;
				hold--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [DATA_W-1:0] key_pool [POOL_SIZE];
		int                spans    [PHASES];
		int                src_pcts [PHASES];
		int                snk_pcts [PHASES];
		int                get_w;
		int                ins_w;
		int                rem_w;
		int                span;
		int unsigned       roll;
		cmd_t              cmd;
		logic [DATA_W-1:0] k;

		spans    = '{20, 6, 32, 17, 12, 24};
		src_pcts = '{25, 10, 0, 35, 15, 0};
		snk_pcts = '{10, 30, 20, 0, 35, 0};
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		src_gap_pct = 20;
		snk_gap_pct = 20;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_GET;
		req_ch.key <= '0;
		req_ch.value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Empty store, key and value extremes, an update, a stored all-ones value,
		// a repeated remove and the unused command code.
		issue(CMD_GET,    32'h0000_0005, 32'h0000_0000);
		issue(CMD_REMOVE, 32'h0000_0005, 32'h0000_0000);
		issue(CMD_UNUSED, 32'h0000_0005, 32'hFFFF_FFFF);
		issue(CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
		issue(CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
		issue(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
		issue(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(CMD_GET,    32'h8000_0000, 32'h0000_0000);
		issue(CMD_GET,    32'hFFFF_FFFF, 32'h0000_0000);
		issue(CMD_GET,    32'h7FFF_FFFF, 32'hFFFF_FFFF);
		issue(CMD_INSERT, 32'h0000_0000, 32'h1234_5678);
		issue(CMD_GET,    32'h0000_0000, 32'h0000_0000);
		issue(CMD_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000);
		issue(CMD_GET,    32'h7FFF_FFFF, 32'h0000_0000);
		issue(CMD_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000);
		issue(CMD_UNUSED, 32'h8000_0000, 32'h0000_0000);
		issue(CMD_GET,    32'h8000_0000, 32'h0000_0000);
		issue(CMD_INSERT, 32'h7FFF_FFFF, 32'h5555_AAAA);
		issue(CMD_REMOVE, 32'h8000_0000, 32'h0000_0000);
		issue(CMD_GET,    32'h7FFF_FFFF, 32'h0000_0000);

		// Random phases over a small key pool, so hits, refills and evictions
		// all happen; a few keys are fresh random patterns that mostly miss.
		for (int p = 0; p < PHASES; p++) begin
			span = spans[p];
			src_gap_pct = src_pcts[p];
			snk_gap_pct = snk_pcts[p];
			case (p % 3)
				0: begin get_w = 30; ins_w = 55; rem_w = 10; end
				1: begin get_w = 45; ins_w = 35; rem_w = 15; end
				default: begin get_w = 35; ins_w = 20; rem_w = 40; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < get_w)
					cmd = CMD_GET;
				else if (roll < get_w + ins_w)
					cmd = CMD_INSERT;
				else if (roll < get_w + ins_w + rem_w)
					cmd = CMD_REMOVE;
				else
					cmd = CMD_UNUSED;
				if ($urandom_range(0, 9) == 0)
					k = $urandom;
				else
					k = key_pool[$urandom_range(0, span - 1)];
				issue(cmd, k, $urandom);
			end
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (3 * CAPACITY + 10) @(posedge clk);

		$display("Covered %0d request/response transactions: %0d get hits, %0d evictions,",
			answered, get_hits, evictions);
		$display("with idle bursts on both channels and a final stretch without any.");
		if (errors == 0)
			$display("lru_key_value_cache: match");
		else
			$display("lru_key_value_cache: mismatch");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/lkv_pkg.sv
hdl/lkv_if.sv
hdl/lkv_ram.sv
hdl/lkv_scan.sv
hdl/lru_key_value_cache.sv
tb/lru_key_value_cache_checker.sv
tb/lru_key_value_cache_test.sv
